### hw/rtl/tcc_pkg.sv
`timescale 1ns / 1ps
// Types and constants shared by the text console cursor block and its channel interfaces.
package tcc_pkg;

  localparam int unsigned CodeW   = 8;
  localparam int unsigned PosXW   = 10;
  localparam int unsigned PosYW   = 9;
  localparam int unsigned GlyphXW = 8;
  localparam int unsigned GlyphYW = 9;
  localparam int unsigned RowW    = 9;

  localparam logic [CodeW-1:0] CODE_STOP      = 8'd33;
  localparam logic [CodeW-1:0] CODE_NEWLINE   = 8'd10;
  localparam logic [CodeW-1:0] CODE_BACKSPACE = 8'd127;

  localparam logic [PosYW-1:0] Y_LIMIT = 9'd480;
  localparam logic [PosXW-1:0] X_LIMIT = 10'd1023;

  localparam logic [RowW-1:0] CLEAR_ROW_RST  = 9'd394;
  localparam logic [RowW-1:0] SWITCH_ROW_RST = 9'd374;

  typedef enum logic [1:0] {
    ACT_DRAW,
    ACT_CLEAR_CELL,
    ACT_CLEAR_AREA,
    ACT_STOP
  } action_e;

  // Register index taken from the word address
  typedef enum logic {
    REG_CLEAR_ROW,
    REG_SWITCH_ROW
  } reg_idx_e;

  typedef struct packed {
    action_e              action;
    logic [PosXW-1:0]     pos_x;
    logic [PosYW-1:0]     pos_y;
    logic [GlyphXW-1:0]   glyph_x;
    logic [GlyphYW-1:0]   glyph_y;
    logic                 last;
  } cmd_t;

endpackage

### hw/rtl/tcc_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for character beats in and drawing command beats out.
interface tcc_in_if
  import tcc_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CodeW-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface tcc_out_if
  import tcc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [PosXW-1:0]   pos_x;
  logic [PosYW-1:0]   pos_y;
  logic [GlyphXW-1:0] glyph_x;
  logic [GlyphYW-1:0] glyph_y;
  logic               last;

  modport source (output valid, output action, output pos_x, output pos_y,
                  output glyph_x, output glyph_y, output last, input ready);
  modport sink   (input valid, input action, input pos_x, input pos_y,
                  input glyph_x, input glyph_y, input last, output ready);
endinterface

### hw/rtl/text_console_cursor.sv
`timescale 1ns / 1ps
// Text console cursor: turns character beats into drawing command beats.
// Command beats are queued as their character is accepted and leave on out_o in order.
// Throughput: one character per cycle while in_i.ready is high; a text-area clear adds
//   a second beat; the four-entry queue drains one beat a cycle as out_o.ready allows.
// in_i.ready is high while the queue has room for two more beats.
// Reset: cursor at (0, 0), running, clear_row 394, spacing_switch_row 374, queue empty.
module text_console_cursor
  import tcc_pkg::*;
#(
  parameter int unsigned CELL_WIDTH   = 10,
  parameter int unsigned LINE_HEIGHT  = 21,
  parameter int unsigned SCREEN_W     = 640,
  parameter int unsigned SHEET_CELL_W = 12,
  parameter int unsigned SHEET_CELL_H = 23
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tcc_in_if.sink      in_i,
  tcc_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Widths for cursor arithmetic: x gets one spare bit so a full line (up to 1024)
  // and the advanced cursor compare without wrapping.
  localparam logic [PosXW:0]   ScreenW   = (PosXW + 1)'(SCREEN_W);
  localparam logic [PosXW:0]   CellW     = (PosXW + 1)'(CELL_WIDTH);
  localparam logic [PosXW-1:0] LineEndX  =
    (SCREEN_W - CELL_WIDTH > 1023) ? 10'd1023 : PosXW'(SCREEN_W - CELL_WIDTH);
  localparam logic [6:0]       PitchLow  = 7'(LINE_HEIGHT);
  localparam logic [6:0]       PitchHigh = 7'(LINE_HEIGHT + 1);
  localparam logic [9:0]       SheetW    = 10'(SHEET_CELL_W);
  localparam logic [9:0]       SheetH    = 10'(SHEET_CELL_H);

  localparam int unsigned QDepth = 4;
  localparam int unsigned PtrW   = $clog2(QDepth);
  localparam int unsigned CntW   = $clog2(QDepth + 1);

  // --------------------------------------------------------------------------
  // Configuration registers over APB; the word address picks the register.
  // --------------------------------------------------------------------------
  logic [RowW-1:0] clear_row_q, switch_row_q;
  logic            cfg_wr;
  reg_idx_e        cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_e'(paddr[2]);

  always_comb begin
    case (cfg_idx)
      REG_CLEAR_ROW:  prdata = {23'd0, clear_row_q};
      REG_SWITCH_ROW: prdata = {23'd0, switch_row_q};
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_row_q  <= CLEAR_ROW_RST;
      switch_row_q <= SWITCH_ROW_RST;
    end else if (cfg_wr) begin
      if (cfg_idx == REG_CLEAR_ROW) begin
        clear_row_q <= pwdata[RowW-1:0];
      end
      if (cfg_idx == REG_SWITCH_ROW) begin
        switch_row_q <= pwdata[RowW-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output queue: four command beats, up to two pushed per accepted character.
  // --------------------------------------------------------------------------
  cmd_t            fifo_q [QDepth];
  logic [PtrW-1:0] rd_ptr_q, wr_ptr_q, wr_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            in_acc, out_acc;

  assign in_i.ready  = (count_q <= CntW'(QDepth - 2));
  assign in_acc      = in_i.valid & in_i.ready;
  assign out_o.valid = (count_q != '0);
  assign out_acc     = out_o.valid & out_o.ready;

  // --------------------------------------------------------------------------
  // Cursor state and the single-pass update for one character.
  // --------------------------------------------------------------------------
  logic [PosXW-1:0] cur_x_q, cur_x_d;
  logic [PosYW-1:0] cur_y_q, cur_y_d;
  logic             halted_q, halted_d;

  logic [6:0]       pitch;
  logic [PosYW:0]   nl_sum;
  logic [PosYW-1:0] nl_y;
  logic             wrap, area_clr;
  logic [PosXW-1:0] gl_x;
  logic [PosYW-1:0] gl_y1, gl_y;
  logic [PosXW:0]   adv_sum;
  logic [PosXW-1:0] adv_x;
  logic [PosXW-1:0] bs_x_mid;
  logic [PosYW-1:0] bs_y_up;
  logic [9:0]       glyph_x_w, glyph_y_w;
  logic [1:0]       n_res;
  cmd_t             res0, res1;

  // Line pitch depends on the current row; newline saturates at the bottom.
  assign pitch   = (cur_y_q >= switch_row_q) ? PitchLow : PitchHigh;
  assign nl_sum  = {1'b0, cur_y_q} + {3'd0, pitch};
  assign nl_y    = (nl_sum > {1'b0, Y_LIMIT}) ? Y_LIMIT : nl_sum[PosYW-1:0];

  // Glyph path: wrap a full line first, then clear the text area if the row is low enough.
  assign wrap     = ({1'b0, cur_x_q} >= ScreenW);
  assign gl_x     = wrap ? '0 : cur_x_q;
  assign gl_y1    = wrap ? nl_y : cur_y_q;
  assign area_clr = (gl_y1 >= clear_row_q);
  assign gl_y     = area_clr ? '0 : gl_y1;
  assign adv_sum  = {1'b0, gl_x} + CellW;
  assign adv_x    = (adv_sum > {1'b0, X_LIMIT}) ? X_LIMIT : adv_sum[PosXW-1:0];

  // Glyph sheet source: low nibble picks the column, high nibble the row.
  assign glyph_x_w = {6'd0, in_i.char_code[3:0]} * SheetW + 10'd1;
  assign glyph_y_w = {6'd0, in_i.char_code[7:4]} * SheetH + 10'd1;

  // Backspace: step back within the line, or up to the end of the previous line.
  assign bs_x_mid = ({1'b0, cur_x_q} >= CellW) ? (cur_x_q - CellW[PosXW-1:0]) : '0;
  assign bs_y_up  = (cur_y_q >= {2'd0, pitch}) ? (cur_y_q - {2'd0, pitch}) : '0;

  always_comb begin
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    halted_d = halted_q;
    n_res    = 2'd0;
    res0     = '0;
    res1     = '0;
    if (in_acc && !halted_q) begin
      case (in_i.char_code)
        CODE_STOP: begin
          halted_d    = 1'b1;
          n_res       = 2'd1;
          res0.action = ACT_STOP;
          res0.last   = 1'b1;
        end
        CODE_NEWLINE: begin
          cur_x_d = '0;
          cur_y_d = nl_y;
        end
        CODE_BACKSPACE: begin
          // Drop backspace at the origin
          if (cur_x_q != '0 || cur_y_q != '0) begin
            if (cur_x_q != '0) begin
              cur_x_d = bs_x_mid;
            end else begin
              cur_x_d = LineEndX;
              cur_y_d = bs_y_up;
            end
            n_res       = 2'd1;
            res0.action = ACT_CLEAR_CELL;
            res0.pos_x  = (cur_x_q != '0) ? bs_x_mid : LineEndX;
            res0.pos_y  = (cur_x_q != '0) ? cur_y_q : bs_y_up;
            res0.last   = 1'b1;
          end
        end
        default: begin
          cmd_t draw;
          draw         = '0;
          draw.action  = ACT_DRAW;
          draw.pos_x   = gl_x;
          draw.pos_y   = gl_y;
          draw.glyph_x = glyph_x_w[GlyphXW-1:0];
          draw.glyph_y = glyph_y_w[GlyphYW-1:0];
          draw.last    = 1'b1;
          cur_x_d      = adv_x;
          cur_y_d      = gl_y;
          if (area_clr) begin
            n_res       = 2'd2;
            res0.action = ACT_CLEAR_AREA;
            res1        = draw;
          end else begin
            n_res = 2'd1;
            res0  = draw;
          end
        end
      endcase
    end
  end

  assign wr_ptr_d = wr_ptr_q + PtrW'(n_res);
  assign count_d  = count_q + CntW'(n_res) - CntW'(out_acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      halted_q <= 1'b0;
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      cur_x_q  <= cur_x_d;
      cur_y_q  <= cur_y_d;
      halted_q <= halted_d;
      wr_ptr_q <= wr_ptr_d;
      count_q  <= count_d;
      if (out_acc) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
    end
  end

  // Queue payload holds no reset; entries are only read once counted in.
  always_ff @(posedge clk_i) begin
    if (n_res != 2'd0) begin
      fifo_q[wr_ptr_q] <= res0;
    end
    if (n_res == 2'd2) begin
      fifo_q[wr_ptr_q + PtrW'(1)] <= res1;
    end
  end

  cmd_t head;
  assign head          = fifo_q[rd_ptr_q];
  assign out_o.action  = head.action;
  assign out_o.pos_x   = head.pos_x;
  assign out_o.pos_y   = head.pos_y;
  assign out_o.glyph_x = head.glyph_x;
  assign out_o.glyph_y = head.glyph_y;
  assign out_o.last    = head.last;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QDepth))
    else $error("output queue over-filled");

  a_room_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> count_q <= CntW'(QDepth - 2))
    else $error("character taken without room for two beats");

  a_halt_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halted flag cleared without reset");

  a_halted_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> count_q <= $past(count_q))
    else $error("command pushed while halted");

  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_y_q <= Y_LIMIT)
    else $error("cursor row beyond bottom limit");

endmodule
